// File: rtl/cda_pkg.sv
// ----------------------------------------------------------------------------
// cda_pkg: shared types and functions for the calendar date adder
// Request format, operation codes, back-end states and Gregorian month rules.
// ----------------------------------------------------------------------------
package cda_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [15:0] YearMax  = 16'hFFFF;
  localparam logic [15:0] Inv25    = 16'h5C29;
  localparam logic [15:0] Mul25Max = 16'd2621;
  localparam logic [3:0]  MonthMax = 4'd12;

  typedef enum logic [1:0] {
    OpDays   = 2'd0,
    OpMonths = 2'd1,
    OpYears  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    BkIdle,
    BkRun,
    BkFinish
  } back_state_e;

  typedef struct packed {
    op_e         op;
    logic [14:0] amount;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
  } date_req_t;

  typedef struct packed {
    logic      empty;
    date_req_t req;
  } queue_head_t;

  function automatic logic leap_year(input logic [15:0] y);
    logic [31:0] prod;
    logic        div25;
    prod  = 32'(y) * 32'(Inv25);
    div25 = (prod[15:0] <= Mul25Max);
    return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
  endfunction

  function automatic logic [4:0] month_length(input logic [15:0] y, input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap_year(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/cda_front.sv
// ----------------------------------------------------------------------------
// cda_front: request intake
// Takes an item, brings the start date into range and pushes it to the queue.
// ----------------------------------------------------------------------------
module cda_front (
  input  logic                 push,
  input  logic [1:0]           op_i,
  input  logic [14:0]          amount_i,
  input  logic [4:0]           start_day_i,
  input  logic [3:0]           start_month_i,
  input  logic [15:0]          start_year_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output cda_pkg::date_req_t   q_req_o
);
  import cda_pkg::*;

  logic [3:0]  month;
  logic [15:0] year;
  logic [4:0]  day;
  logic [4:0]  len;

  always_comb begin
    if (start_month_i == 4'd0) begin
      month = 4'd1;
    end else if (start_month_i > MonthMax) begin
      month = MonthMax;
    end else begin
      month = start_month_i;
    end
    year = (start_year_i == 16'd0) ? 16'd1 : start_year_i;
    day  = (start_day_i == 5'd0) ? 5'd1 : start_day_i;
    len  = month_length(year, month);
    if (day > len) begin
      day = len;
    end
  end

  assign q_push_o       = push && !q_full_i;
  assign q_req_o.op     = op_e'(op_i);
  assign q_req_o.amount = amount_i;
  assign q_req_o.day    = day;
  assign q_req_o.month  = month;
  assign q_req_o.year   = year;

endmodule

// File: rtl/cda_queue.sv
// ----------------------------------------------------------------------------
// cda_queue: request queue
// Short FIFO that decouples intake from the date stepper.
// ----------------------------------------------------------------------------
module cda_queue #(
  parameter int unsigned Depth = cda_pkg::QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  cda_pkg::date_req_t    req_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output cda_pkg::queue_head_t  head_o
);
  import cda_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  date_req_t       mem [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == CntFull);
  assign head_o.empty = (cnt_q == '0);
  assign head_o.req   = mem[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !head_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= req_i;
    end
  end

endmodule

// File: rtl/cda_back.sv
// ----------------------------------------------------------------------------
// cda_back: date stepper
// Steps days or months one per cycle, adds years at once, holds the result.
// ----------------------------------------------------------------------------
module cda_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cda_pkg::queue_head_t  head_i,
  output logic                  q_pop_o,
  input  logic                  pop,
  output logic                  empty,
  output logic [4:0]            end_day_o,
  output logic [3:0]            end_month_o,
  output logic [15:0]           end_year_o,
  output logic                  year_overflow_o
);
  import cda_pkg::*;

  back_state_e state_q, state_d;
  op_e         op_q, op_d;
  logic [14:0] cnt_q, cnt_d;
  logic [4:0]  day_q, day_d;
  logic [3:0]  month_q, month_d;
  logic [15:0] year_q, year_d;
  logic        ovf_q, ovf_d;
  logic        out_valid_q, out_valid_d;
  logic        out_load;
  logic [4:0]  len;
  logic [16:0] year_sum;
  logic [4:0]  out_day_q, out_day_d;
  logic [3:0]  out_month_q;
  logic [15:0] out_year_q;
  logic        out_ovf_q;

  assign len      = month_length(year_q, month_q);
  assign year_sum = 17'(year_q) + 17'(cnt_q);
  assign out_day_d = (day_q > len) ? len : day_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    day_d       = day_q;
    month_d     = month_q;
    year_d      = year_q;
    ovf_d       = ovf_q;
    q_pop_o     = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !pop;
    case (state_q)
      BkIdle: begin
        if (!head_i.empty) begin
          q_pop_o = 1'b1;
          op_d    = head_i.req.op;
          cnt_d   = head_i.req.amount;
          day_d   = head_i.req.day;
          month_d = head_i.req.month;
          year_d  = head_i.req.year;
          ovf_d   = 1'b0;
          state_d = BkRun;
        end
      end
      BkRun: begin
        case (op_q)
          OpDays: begin
            if (cnt_q == '0) begin
              state_d = BkFinish;
            end else begin
              cnt_d = cnt_q - 1'b1;
              if (day_q < len) begin
                day_d = day_q + 1'b1;
              end else if (month_q < MonthMax) begin
                month_d = month_q + 1'b1;
                day_d   = 5'd1;
              end else if (year_q < YearMax) begin
                year_d  = year_q + 1'b1;
                month_d = 4'd1;
                day_d   = 5'd1;
              end else begin
                ovf_d   = 1'b1;
                state_d = BkFinish;
              end
            end
          end
          OpMonths: begin
            if (cnt_q == '0) begin
              state_d = BkFinish;
            end else begin
              cnt_d = cnt_q - 1'b1;
              day_d = out_day_d;
              if (month_q < MonthMax) begin
                month_d = month_q + 1'b1;
              end else if (year_q < YearMax) begin
                year_d  = year_q + 1'b1;
                month_d = 4'd1;
              end else begin
                ovf_d   = 1'b1;
                state_d = BkFinish;
              end
            end
          end
          OpYears: begin
            if (year_sum[16]) begin
              year_d = YearMax;
              ovf_d  = 1'b1;
            end else begin
              year_d = year_sum[15:0];
            end
            state_d = BkFinish;
          end
          default: begin
            state_d = BkFinish;
          end
        endcase
      end
      BkFinish: begin
        if (!out_valid_q || pop) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = BkIdle;
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    cnt_q   <= cnt_d;
    day_q   <= day_d;
    month_q <= month_d;
    year_q  <= year_d;
    ovf_q   <= ovf_d;
    if (out_load) begin
      out_day_q   <= out_day_d;
      out_month_q <= month_q;
      out_year_q  <= year_q;
      out_ovf_q   <= ovf_q;
    end
  end

  assign empty           = !out_valid_q;
  assign end_day_o       = out_day_q;
  assign end_month_o     = out_month_q;
  assign end_year_o      = out_year_q;
  assign year_overflow_o = out_ovf_q;

endmodule

// File: rtl/calendar_date_adder_core.sv
// ----------------------------------------------------------------------------
// calendar_date_adder_core: Gregorian date adder, top level
// The date stepper advances one day or one month per cycle, adds years at once
//   and takes one item at a time, from idle through run to finish; it waits in
//   finish while the previous result is still held and not popped.
// Reset: asynchronous, clears queue and stepper control; no result pending.
// ----------------------------------------------------------------------------
module calendar_date_adder_core #(
  parameter int unsigned QueueDepth = cda_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op_i,
  input  logic [14:0] amount_i,
  input  logic [4:0]  start_day_i,
  input  logic [3:0]  start_month_i,
  input  logic [15:0] start_year_i,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  end_day_o,
  output logic [3:0]  end_month_o,
  output logic [15:0] end_year_o,
  output logic        year_overflow_o
);
  import cda_pkg::*;

  logic        q_push;
  logic        q_pop;
  date_req_t   q_req;
  queue_head_t q_head;

  cda_front u_front (
    .push          (push),
    .op_i          (op_i),
    .amount_i      (amount_i),
    .start_day_i   (start_day_i),
    .start_month_i (start_month_i),
    .start_year_i  (start_year_i),
    .q_full_i      (full),
    .q_push_o      (q_push),
    .q_req_o       (q_req)
  );

  cda_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .req_i  (q_req),
    .full_o (full),
    .pop_i  (q_pop),
    .head_o (q_head)
  );

  cda_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (q_head),
    .q_pop_o         (q_pop),
    .pop             (pop),
    .empty           (empty),
    .end_day_o       (end_day_o),
    .end_month_o     (end_month_o),
    .end_year_o      (end_year_o),
    .year_overflow_o (year_overflow_o)
  );

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for calendar_date_adder_core
// Drives date items through the push/full side and drains results through
// pop/empty, both with random idle bursts. A table of directed items covers
// the field extremes, every operation and the corner cases. Random items
// follow. Results are compared with typed rows or a Gregorian date stepper.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  OpUnused     = 2'd3;
  localparam int unsigned TableRows    = 23;
  localparam int unsigned RandomItems  = 77;
  localparam int unsigned CalmItems    = 20;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned SettleCycles = 16;

  typedef struct packed {
    logic [1:0]  op;
    logic [14:0] amount;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
  } date_cmd_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic        ovf;
  } date_res_t;

  typedef struct packed {
    date_cmd_t cmd;
    bit        typed;
    date_res_t res;
  } date_row_t;

  localparam date_row_t DateTable [TableRows] = '{
    '{'{cda_pkg::OpDays,   0,     31, 12, 65535}, 1, '{31, 12, 65535, 1'b0}},
    '{'{cda_pkg::OpDays,   1,     31, 12, 65535}, 1, '{31, 12, 65535, 1'b1}},
    '{'{cda_pkg::OpMonths, 1,     15, 12, 65535}, 1, '{15, 12, 65535, 1'b1}},
    '{'{cda_pkg::OpYears,  32767, 29, 2,  40000}, 1, '{28, 2,  65535, 1'b1}},
    '{'{OpUnused,          5,     0,  0,  0},     1, '{1,  1,  1,     1'b0}},
    '{'{cda_pkg::OpDays,   0,     31, 2,  2024},  1, '{29, 2,  2024,  1'b0}},
    '{'{cda_pkg::OpDays,   0,     5,  15, 100},   1, '{5,  12, 100,   1'b0}},
    '{'{cda_pkg::OpYears,  1,     29, 2,  2024},  1, '{28, 2,  2025,  1'b0}},
    '{'{cda_pkg::OpYears,  400,   29, 2,  2000},  1, '{29, 2,  2400,  1'b0}},
    '{'{cda_pkg::OpYears,  0,     31, 4,  1},     1, '{30, 4,  1,     1'b0}},
    '{'{cda_pkg::OpDays,   1,     28, 2,  1900},  1, '{1,  3,  1900,  1'b0}},
    '{'{cda_pkg::OpDays,   1,     28, 2,  2000},  1, '{29, 2,  2000,  1'b0}},
    '{'{cda_pkg::OpDays,   32767, 1,  1,  1},     0, '{0,  0,  0,     1'b0}},
    '{'{cda_pkg::OpMonths, 32767, 31, 1,  1},     0, '{0,  0,  0,     1'b0}},
    '{'{cda_pkg::OpMonths, 1,     31, 1,  2023},  1, '{28, 2,  2023,  1'b0}},
    '{'{cda_pkg::OpDays,   1,     31, 12, 1999},  1, '{1,  1,  2000,  1'b0}},
    '{'{cda_pkg::OpYears,  32767, 1,  1,  32768}, 1, '{1,  1,  65535, 1'b0}},
    '{'{cda_pkg::OpYears,  32767, 1,  1,  32769}, 1, '{1,  1,  65535, 1'b1}},
    '{'{cda_pkg::OpDays,   365,   1,  1,  65535}, 1, '{31, 12, 65535, 1'b1}},
    '{'{cda_pkg::OpMonths, 12,    31, 3,  65534}, 0, '{0,  0,  0,     1'b0}},
    '{'{cda_pkg::OpMonths, 32767, 31, 0,  65535}, 1, '{28, 12, 65535, 1'b1}},
    '{'{cda_pkg::OpDays,   59,    1,  1,  2100},  0, '{0,  0,  0,     1'b0}},
    '{'{OpUnused,          32767, 31, 15, 65535}, 1, '{31, 12, 65535, 1'b0}}
  };

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        push            = 1'b0;
  logic        full;
  logic [1:0]  op_i            = '0;
  logic [14:0] amount_i        = '0;
  logic [4:0]  start_day_i     = '0;
  logic [3:0]  start_month_i   = '0;
  logic [15:0] start_year_i    = '0;
  logic        empty;
  logic        pop             = 1'b0;
  logic [4:0]  end_day_o;
  logic [3:0]  end_month_o;
  logic [15:0] end_year_o;
  logic        year_overflow_o;

  date_res_t   expected_dates [$];
  bit          idling_on = 1'b1;
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned saturations;
  int unsigned op_count [4];

  calendar_date_adder_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .op_i            (op_i),
    .amount_i        (amount_i),
    .start_day_i     (start_day_i),
    .start_month_i   (start_month_i),
    .start_year_i    (start_year_i),
    .empty           (empty),
    .pop             (pop),
    .end_day_o       (end_day_o),
    .end_month_o     (end_month_o),
    .end_year_o      (end_year_o),
    .year_overflow_o (year_overflow_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
  endfunction

  function automatic int unsigned days_in(input int unsigned y, input int unsigned m);
    int unsigned len;
    case (m)
      2:             len = is_leap(y) ? 29 : 28;
      4, 6, 9, 11:   len = 30;
      default:       len = 31;
    endcase
    return len;
  endfunction

  function automatic date_res_t advance_date(input date_cmd_t c);
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned n;
    logic        ovf;
    date_res_t   r;
    d   = c.day;
    m   = c.month;
    y   = c.year;
    ovf = 1'b0;
    if (m == 0) m = 1;
    if (m > cda_pkg::MonthMax) m = cda_pkg::MonthMax;
    if (y == 0) y = 1;
    if (d == 0) d = 1;
    if (d > days_in(y, m)) d = days_in(y, m);
    if (c.op == cda_pkg::OpDays) begin
      for (n = 0; n < c.amount; n++) begin
        if (d < days_in(y, m)) begin
          d++;
        end else if (m < cda_pkg::MonthMax) begin
          m++;
          d = 1;
        end else if (y < cda_pkg::YearMax) begin
          y++;
          m = 1;
          d = 1;
        end else begin
          ovf = 1'b1;
          break;
        end
      end
    end else if (c.op == cda_pkg::OpMonths) begin
      for (n = 0; n < c.amount; n++) begin
        if (m < cda_pkg::MonthMax) begin
          m++;
        end else if (y < cda_pkg::YearMax) begin
          y++;
          m = 1;
        end else begin
          ovf = 1'b1;
          break;
        end
        if (d > days_in(y, m)) d = days_in(y, m);
      end
    end else if (c.op == cda_pkg::OpYears) begin
      y = y + c.amount;
      if (y > cda_pkg::YearMax) begin
        y   = cda_pkg::YearMax;
        ovf = 1'b1;
      end
      if (d > days_in(y, m)) d = days_in(y, m);
    end
    r.day   = 5'(d);
    r.month = 4'(m);
    r.year  = 16'(y);
    r.ovf   = ovf;
    return r;
  endfunction

  function automatic date_cmd_t random_cmd();
    date_cmd_t   c;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    c.op = (pick == 0) ? OpUnused : 2'($urandom_range(0, 2));
    pick = $urandom_range(0, 99);
    if (pick < 70) c.amount = 15'($urandom_range(0, 400));
    else if (pick < 90) c.amount = 15'($urandom_range(0, 4000));
    else if (pick < 97) c.amount = 15'($urandom);
    else c.amount = '1;
    c.day   = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 31));
    c.month = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12));
    pick = $urandom_range(0, 9);
    if (pick < 4) c.year = 16'($urandom_range(1, 3000));
    else if (pick < 6) c.year = 16'(100 * $urandom_range(0, 655));
    else if (pick < 8) c.year = 16'($urandom_range(65000, 65535));
    else c.year = 16'($urandom);
    return c;
  endfunction

  // hold the item on the ports until the block takes it
  task automatic offer_date(input date_cmd_t c, input date_res_t want);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap  = $urandom_range(1, 6);
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push          = 1'b1;
    op_i          = c.op;
    amount_i      = c.amount;
    start_day_i   = c.day;
    start_month_i = c.month;
    start_year_i  = c.year;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    expected_dates.push_back(want);
    op_count[c.op]++;
    if (want.ovf) saturations++;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    date_cmd_t c;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (DateTable[i]) begin
      c = DateTable[i].cmd;
      offer_date(c, DateTable[i].typed ? DateTable[i].res : advance_date(c));
    end
    // drain everything before the random part
    push = 1'b0;
    while (expected_dates.size() != 0) @(negedge clk_i);
    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems - CalmItems) idling_on = 1'b0;
      c = random_cmd();
      offer_date(c, advance_date(c));
    end
    push = 1'b0;
    while (expected_dates.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    $display("Covered %0d items (%0d table rows, %0d random): days %0d, months %0d, years %0d, unused op %0d",
             TableRows + RandomItems, TableRows, RandomItems,
             op_count[cda_pkg::OpDays], op_count[cda_pkg::OpMonths],
             op_count[cda_pkg::OpYears], op_count[OpUnused]);
    $display("Checked %0d results, %0d with year saturation, %0d mismatches",
             results_checked, saturations, mismatches);
    if (mismatches == 0) begin
      $display("** calendar_date_adder_core: PASSED **");
    end else begin
      $display("** calendar_date_adder_core: FAILED **");
    end
    $finish;
  end

  initial begin : drain
    int unsigned stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        pop = 1'b0;
        stall--;
      end else begin
        pop = 1'b1;
        if (idling_on && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 6);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    date_res_t got;
    date_res_t want;
    if (rst_ni && pop && !empty) begin
      got = '{end_day_o, end_month_o, end_year_o, year_overflow_o};
      if (expected_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("%0t: unexpected result %0d-%0d-%0d ovf %0b", $realtime,
                   got.year, got.month, got.day, got.ovf);
        end
      end else begin
        want = expected_dates.pop_front();
        results_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("%0t: mismatch, expected %0d-%0d-%0d ovf %0b, got %0d-%0d-%0d ovf %0b",
                     $realtime, want.year, want.month, want.day, want.ovf,
                     got.year, got.month, got.day, got.ovf);
          end
        end
      end
    end
  end

  initial begin : watchdog
    #100ms;
    $display("** calendar_date_adder_core: FAILED **");
    $finish;
  end

endmodule
